[rtl/gbf_to_rtf_markup_converter_unit_assert.svh]
// Assertion macros for the markup converter checker.
// Depends on nothing; included by the checker file.
`ifndef GBF_TO_RTF_MARKUP_CONVERTER_UNIT_ASSERT_SVH
`define GBF_TO_RTF_MARKUP_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define G2R_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define G2R_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/g2r_pkg.sv]
// Shared types, character codes, microcode and string tables of the markup converter.
// Depends on nothing; used by the sequencer, the datapath and the top level.
package g2r_pkg;

    typedef logic [4:0] pc_t;
    typedef logic [5:0] str_addr_t;

    typedef enum logic [3:0] {
        OP_WAIT     = 4'd0,
        OP_OPEN     = 4'd1,
        OP_STORE    = 4'd2,
        OP_PASS     = 4'd3,
        OP_END      = 4'd4,
        OP_TRANS    = 4'd5,
        OP_STR      = 4'd6,
        OP_IDX_INIT = 4'd7,
        OP_TAIL     = 4'd8,
        OP_WS       = 4'd9,
        OP_SIGN     = 4'd10,
        OP_DIGIT    = 4'd11,
        OP_EMIT_ACC = 4'd12
    } op_t;

    typedef struct packed {
        op_t       op;
        str_addr_t arg;
        logic      last;
        pc_t       next;
    } ctrl_t;

    typedef struct packed {
        logic done;
        logic jump;
        pc_t  target;
    } stat_t;

    // Program addresses.
    localparam pc_t PC_WAIT      = 5'd0;
    localparam pc_t PC_OPEN      = 5'd1;
    localparam pc_t PC_STORE     = 5'd2;
    localparam pc_t PC_PASS      = 5'd3;
    localparam pc_t PC_END       = 5'd4;
    localparam pc_t PC_TRANS     = 5'd5;
    localparam pc_t PC_WG        = 5'd6;
    localparam pc_t PC_WG_INIT   = 5'd7;
    localparam pc_t PC_WG_TAIL   = 5'd8;
    localparam pc_t PC_WG_CLOSE  = 5'd9;
    localparam pc_t PC_WT        = 5'd10;
    localparam pc_t PC_WT_INIT   = 5'd11;
    localparam pc_t PC_WT_TAIL   = 5'd12;
    localparam pc_t PC_WT_CLOSE  = 5'd13;
    localparam pc_t PC_RF_UP     = 5'd14;
    localparam pc_t PC_RF_LO     = 5'd15;
    localparam pc_t PC_FI_UP     = 5'd16;
    localparam pc_t PC_FI_LO     = 5'd17;
    localparam pc_t PC_FB_UP     = 5'd18;
    localparam pc_t PC_FB_LO     = 5'd19;
    localparam pc_t PC_CG        = 5'd20;
    localparam pc_t PC_CL        = 5'd21;
    localparam pc_t PC_CM        = 5'd22;
    localparam pc_t PC_CT        = 5'd23;
    localparam pc_t PC_CA_INIT   = 5'd24;
    localparam pc_t PC_CA_WS     = 5'd25;
    localparam pc_t PC_CA_SIGN   = 5'd26;
    localparam pc_t PC_CA_DIGIT  = 5'd27;
    localparam pc_t PC_CA_EMIT   = 5'd28;

    // Character codes.
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_PLS = 8'h2B;
    localparam logic [7:0] CH_MIN = 8'h2D;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_LT  = 8'h3C;
    localparam logic [7:0] CH_GT  = 8'h3E;

    // Start addresses of the fixed strings in the string table.
    localparam str_addr_t STR_W_OPEN   = 6'd0;
    localparam str_addr_t STR_WG_CLOSE = 6'd8;
    localparam str_addr_t STR_WT_OPEN  = 6'd10;
    localparam str_addr_t STR_WT_CLOSE = 6'd18;
    localparam str_addr_t STR_RF_UP    = 6'd20;
    localparam str_addr_t STR_RF_LO    = 6'd32;
    localparam str_addr_t STR_FI_UP    = 6'd35;
    localparam str_addr_t STR_FI_LO    = 6'd39;
    localparam str_addr_t STR_FB_UP    = 6'd43;
    localparam str_addr_t STR_FB_LO    = 6'd47;
    localparam str_addr_t STR_CG       = 6'd51;
    localparam str_addr_t STR_CL       = 6'd52;
    localparam str_addr_t STR_CM       = 6'd58;
    localparam str_addr_t STR_CT       = 6'd63;
    localparam str_addr_t TAG_ARG_TWO  = 6'd2;
    localparam str_addr_t TAG_ARG_THREE = 6'd3;
    localparam str_addr_t ARG_NONE     = 6'd0;

    localparam int StrRomDepth = 64;

    // All fixed strings back to back; entry 0 sits in the top byte.
    localparam logic [8*StrRomDepth-1:0] STR_TEXT = {
        "{\\fs15 <", ">}", "{\\fs15 (", ")}", "{\\i1 \\fs15 (", ") }",
        "\\i1 ", "\\i0 ", "\\b1 ", "\\b0 ", ">", "\\line ", "\\par ", "<"
    };

    function automatic logic [7:0] str_byte(input str_addr_t addr);
        return STR_TEXT[(StrRomDepth - 1 - int'(addr)) * 8 +: 8];
    endfunction

    // True on the final byte of each string.
    function automatic logic str_end(input str_addr_t addr);
        return addr inside {6'd7, 6'd9, 6'd17, 6'd19, 6'd31, 6'd34, 6'd38,
                            6'd42, 6'd46, 6'd50, 6'd51, 6'd57, 6'd62, 6'd63};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    endfunction

    // Entry of the routine for a tag, by its first two bytes.
    function automatic pc_t trans_target(input logic [7:0] a, input logic [7:0] b);
        pc_t t;
        t = PC_WAIT;
        case (a)
            "W":
            begin
                if (b == "G" || b == "H") t = PC_WG;
                else if (b == "T") t = PC_WT;
            end
            "R":
            begin
                if (b == "F") t = PC_RF_UP;
                else if (b == "f") t = PC_RF_LO;
            end
            "F":
            begin
                if (b == "I") t = PC_FI_UP;
                else if (b == "i") t = PC_FI_LO;
                else if (b == "B") t = PC_FB_UP;
                else if (b == "b") t = PC_FB_LO;
            end
            "C":
            begin
                if (b == "A") t = PC_CA_INIT;
                else if (b == "G") t = PC_CG;
                else if (b == "L") t = PC_CL;
                else if (b == "M") t = PC_CM;
                else if (b == "T") t = PC_CT;
            end
            default:
            begin
                t = PC_WAIT;
            end
        endcase
        return t;
    endfunction

    function automatic ctrl_t cw(input op_t op, input str_addr_t arg, input logic last,
                                 input pc_t next);
        ctrl_t w;
        w.op   = op;
        w.arg  = arg;
        w.last = last;
        w.next = next;
        return w;
    endfunction

    // The microprogram.
    function automatic ctrl_t ucode(input pc_t pc);
        ctrl_t w;
        case (pc)
            PC_WAIT:     w = cw(OP_WAIT,     ARG_NONE,      1'b0, PC_WAIT);
            PC_OPEN:     w = cw(OP_OPEN,     ARG_NONE,      1'b0, PC_WAIT);
            PC_STORE:    w = cw(OP_STORE,    ARG_NONE,      1'b0, PC_WAIT);
            PC_PASS:     w = cw(OP_PASS,     ARG_NONE,      1'b1, PC_WAIT);
            PC_END:      w = cw(OP_END,      ARG_NONE,      1'b1, PC_WAIT);
            PC_TRANS:    w = cw(OP_TRANS,    ARG_NONE,      1'b0, PC_WAIT);
            PC_WG:       w = cw(OP_STR,      STR_W_OPEN,    1'b0, PC_WG_INIT);
            PC_WG_INIT:  w = cw(OP_IDX_INIT, TAG_ARG_TWO,   1'b0, PC_WG_TAIL);
            PC_WG_TAIL:  w = cw(OP_TAIL,     ARG_NONE,      1'b0, PC_WG_CLOSE);
            PC_WG_CLOSE: w = cw(OP_STR,      STR_WG_CLOSE,  1'b1, PC_WAIT);
            PC_WT:       w = cw(OP_STR,      STR_WT_OPEN,   1'b0, PC_WT_INIT);
            PC_WT_INIT:  w = cw(OP_IDX_INIT, TAG_ARG_THREE, 1'b0, PC_WT_TAIL);
            PC_WT_TAIL:  w = cw(OP_TAIL,     ARG_NONE,      1'b0, PC_WT_CLOSE);
            PC_WT_CLOSE: w = cw(OP_STR,      STR_WT_CLOSE,  1'b1, PC_WAIT);
            PC_RF_UP:    w = cw(OP_STR,      STR_RF_UP,     1'b1, PC_WAIT);
            PC_RF_LO:    w = cw(OP_STR,      STR_RF_LO,     1'b1, PC_WAIT);
            PC_FI_UP:    w = cw(OP_STR,      STR_FI_UP,     1'b1, PC_WAIT);
            PC_FI_LO:    w = cw(OP_STR,      STR_FI_LO,     1'b1, PC_WAIT);
            PC_FB_UP:    w = cw(OP_STR,      STR_FB_UP,     1'b1, PC_WAIT);
            PC_FB_LO:    w = cw(OP_STR,      STR_FB_LO,     1'b1, PC_WAIT);
            PC_CG:       w = cw(OP_STR,      STR_CG,        1'b1, PC_WAIT);
            PC_CL:       w = cw(OP_STR,      STR_CL,        1'b1, PC_WAIT);
            PC_CM:       w = cw(OP_STR,      STR_CM,        1'b1, PC_WAIT);
            PC_CT:       w = cw(OP_STR,      STR_CT,        1'b1, PC_WAIT);
            PC_CA_INIT:  w = cw(OP_IDX_INIT, TAG_ARG_TWO,   1'b0, PC_CA_WS);
            PC_CA_WS:    w = cw(OP_WS,       ARG_NONE,      1'b0, PC_CA_SIGN);
            PC_CA_SIGN:  w = cw(OP_SIGN,     ARG_NONE,      1'b0, PC_CA_DIGIT);
            PC_CA_DIGIT: w = cw(OP_DIGIT,    ARG_NONE,      1'b0, PC_CA_EMIT);
            PC_CA_EMIT:  w = cw(OP_EMIT_ACC, ARG_NONE,      1'b1, PC_WAIT);
            default:     w = cw(OP_WAIT,     ARG_NONE,      1'b0, PC_WAIT);
        endcase
        return w;
    endfunction

endpackage

[rtl/g2r_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module g2r_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/g2r_seq.sv]
// Microprogram sequencer: step counter, control store and branch selection.
// Depends on g2r_pkg.
module g2r_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  g2r_pkg::stat_t stat,
    output g2r_pkg::ctrl_t ctrl
);

    g2r_pkg::pc_t pc_reg;
    g2r_pkg::pc_t pc_next;

    assign ctrl = g2r_pkg::ucode(pc_reg);

    // A jump from the datapath wins; otherwise a finished step falls through
    // to the successor named in the control word, and an unfinished one repeats.
    always_comb
    begin
        pc_next = pc_reg;
        if (stat.jump)
        begin
            pc_next = stat.target;
        end
        else if (stat.done)
        begin
            pc_next = ctrl.next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= g2r_pkg::PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

[rtl/g2r_dp.sv]
// Datapath of the markup converter: input latch, tag store, parse registers, output register.
// Depends on g2r_pkg and g2r_ram.
module g2r_dp #(
    parameter int TOKEN_CHARS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  g2r_pkg::ctrl_t ctrl,
    output g2r_pkg::stat_t stat,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_byte,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           run_last,
    output logic           text_done
);

    localparam int LW = $clog2(TOKEN_CHARS + 1);
    localparam int AW = $clog2(TOKEN_CHARS);

    logic                  in_tag_reg, in_tag_next;
    logic [LW-1:0]         len_reg, len_next;
    logic [LW-1:0]         idx_reg, idx_next;
    logic [7:0]            byte_reg, byte_next;
    logic [7:0]            tag0_reg, tag0_next;
    logic [7:0]            tag1_reg, tag1_next;
    logic [7:0]            acc_reg, acc_next;
    logic                  neg_reg, neg_next;
    g2r_pkg::str_addr_t    str_ptr_reg, str_ptr_next;
    logic                  str_active_reg, str_active_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_done_reg, out_done_next;

    logic                  ram_we;
    logic [7:0]            rd_data;
    logic                  accept;
    logic                  out_free;
    logic [7:0]            tag_c;
    logic [7:0]            tag_a;
    logic [7:0]            tag_b;
    g2r_pkg::str_addr_t    str_addr;

    g2r_ram #(
        .WIDTH (8),
        .DEPTH (TOKEN_CHARS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (len_reg[AW-1:0]),
        .wdata (byte_reg),
        .raddr (idx_next[AW-1:0]),
        .rdata (rd_data)
    );

    assign in_ready  = (ctrl.op == g2r_pkg::OP_WAIT);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = out_last_reg;
    assign text_done = out_done_reg;

    // The RAM is read at the next index every cycle, so rd_data always holds
    // the entry at idx_reg; positions at or past the tag length read as zero.
    assign tag_c    = (idx_reg < len_reg) ? rd_data : g2r_pkg::CH_NUL;
    assign tag_a    = (len_reg > LW'(0)) ? tag0_reg : g2r_pkg::CH_NUL;
    assign tag_b    = (len_reg > LW'(1)) ? tag1_reg : g2r_pkg::CH_NUL;
    assign str_addr = str_active_reg ? str_ptr_reg : ctrl.arg;

    always_comb
    begin
        in_tag_next     = in_tag_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        byte_next       = byte_reg;
        tag0_next       = tag0_reg;
        tag1_next       = tag1_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        str_ptr_next    = str_ptr_reg;
        str_active_next = str_active_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;
        ram_we          = 1'b0;
        stat            = '{done: 1'b0, jump: 1'b0, target: g2r_pkg::PC_WAIT};

        case (ctrl.op)
            g2r_pkg::OP_WAIT:
            begin
                if (accept)
                begin
                    byte_next = in_byte;
                    stat.jump = 1'b1;
                    if (in_byte == g2r_pkg::CH_NUL)
                        stat.target = g2r_pkg::PC_END;
                    else if (in_byte == g2r_pkg::CH_LT)
                        stat.target = g2r_pkg::PC_OPEN;
                    else if (in_byte == g2r_pkg::CH_GT)
                        stat.target = g2r_pkg::PC_TRANS;
                    else if (in_tag_reg)
                        stat.target = g2r_pkg::PC_STORE;
                    else
                        stat.target = g2r_pkg::PC_PASS;
                end
            end
            g2r_pkg::OP_OPEN:
            begin
                in_tag_next = 1'b1;
                len_next    = '0;
                stat.done   = 1'b1;
            end
            g2r_pkg::OP_STORE:
            begin
                if (len_reg < LW'(TOKEN_CHARS))
                begin
                    ram_we   = 1'b1;
                    len_next = len_reg + LW'(1);
                    if (len_reg == LW'(0))
                        tag0_next = byte_reg;
                    if (len_reg == LW'(1))
                        tag1_next = byte_reg;
                end
                stat.done = 1'b1;
            end
            g2r_pkg::OP_PASS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = byte_reg;
                    out_last_next  = ctrl.last;
                    out_done_next  = 1'b0;
                    stat.done      = 1'b1;
                end
            end
            g2r_pkg::OP_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = g2r_pkg::CH_NUL;
                    out_last_next  = ctrl.last;
                    out_done_next  = 1'b1;
                    in_tag_next    = 1'b0;
                    len_next       = '0;
                    stat.done      = 1'b1;
                end
            end
            g2r_pkg::OP_TRANS:
            begin
                in_tag_next = 1'b0;
                stat.jump   = 1'b1;
                stat.target = g2r_pkg::trans_target(tag_a, tag_b);
            end
            g2r_pkg::OP_STR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = g2r_pkg::str_byte(str_addr);
                    out_last_next  = ctrl.last && g2r_pkg::str_end(str_addr);
                    out_done_next  = 1'b0;
                    if (g2r_pkg::str_end(str_addr))
                    begin
                        str_active_next = 1'b0;
                        stat.done       = 1'b1;
                    end
                    else
                    begin
                        str_ptr_next    = str_addr + 6'd1;
                        str_active_next = 1'b1;
                    end
                end
            end
            g2r_pkg::OP_IDX_INIT:
            begin
                idx_next  = LW'(ctrl.arg);
                acc_next  = 8'h00;
                neg_next  = 1'b0;
                stat.done = 1'b1;
            end
            g2r_pkg::OP_TAIL:
            begin
                if (idx_reg >= len_reg)
                begin
                    stat.done = 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = rd_data;
                    out_last_next  = 1'b0;
                    out_done_next  = 1'b0;
                    idx_next       = idx_reg + LW'(1);
                end
            end
            g2r_pkg::OP_WS:
            begin
                if (g2r_pkg::is_space(tag_c))
                    idx_next = idx_reg + LW'(1);
                else
                    stat.done = 1'b1;
            end
            g2r_pkg::OP_SIGN:
            begin
                if (tag_c == g2r_pkg::CH_PLS || tag_c == g2r_pkg::CH_MIN)
                begin
                    neg_next = (tag_c == g2r_pkg::CH_MIN);
                    idx_next = idx_reg + LW'(1);
                end
                stat.done = 1'b1;
            end
            g2r_pkg::OP_DIGIT:
            begin
                if (tag_c >= g2r_pkg::CH_0 && tag_c <= g2r_pkg::CH_9)
                begin
                    // acc * 10 + digit, kept to eight bits.
                    acc_next = (acc_reg << 3) + (acc_reg << 1) + (tag_c - g2r_pkg::CH_0);
                    idx_next = idx_reg + LW'(1);
                end
                else
                begin
                    stat.done = 1'b1;
                end
            end
            g2r_pkg::OP_EMIT_ACC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = neg_reg ? (8'h00 - acc_reg) : acc_reg;
                    out_last_next  = ctrl.last;
                    out_done_next  = 1'b0;
                    stat.done      = 1'b1;
                end
            end
            default:
            begin
                stat.done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_tag_reg     <= 1'b0;
            len_reg        <= '0;
            idx_reg        <= '0;
            str_active_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_tag_reg     <= in_tag_next;
            len_reg        <= len_next;
            idx_reg        <= idx_next;
            str_active_reg <= str_active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        tag0_reg     <= tag0_next;
        tag1_reg     <= tag1_next;
        acc_reg      <= acc_next;
        neg_reg      <= neg_next;
        str_ptr_reg  <= str_ptr_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

endmodule

[rtl/gbf_to_rtf_markup_converter_unit.sv]
// Top level of the tag-to-RTF markup converter.
// Depends on g2r_pkg, g2r_seq and g2r_dp.
//
// One text byte enters per beat on the in channel; a zero byte ends the text.
// Each accepted byte causes zero or more beats on the out channel, the last of
// them flagged by run_last; the end-of-text byte gives one zero beat with
// text_done set. A '<' opens a tag, later bytes are kept up to TOKEN_CHARS,
// and a '>' turns a known kept tag into fixed RTF text, tag text or a number.
// Steps: every byte passes through the accept step and then its handling
// step, so a new byte is taken only after the last one has been handled.
// A '>' runs a dispatch step and, for a known tag, emits bytes from the
// string table; where tag text is copied, a step sets the tag index and a
// step leaves the copy loop; a numeric character tag is parsed digit by digit.
// The pace is set by the microprogram, which runs one step per cycle.
// The output register holds a result while the receiver stalls; an emit step
// simply repeats until that register frees, and a new byte is taken while the
// last result of the previous byte still waits. Reset returns the step counter
// to the accept step, empties the output register and the kept tag.
module gbf_to_rtf_markup_converter_unit #(
    parameter int TOKEN_CHARS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       text_done
);

    g2r_pkg::ctrl_t ctrl;
    g2r_pkg::stat_t stat;

    g2r_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    g2r_dp #(
        .TOKEN_CHARS (TOKEN_CHARS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .text_done (text_done)
    );

endmodule

[rtl/g2r_checker.sv]
// Port-level checks of the markup converter, bound to its top level.
// Depends on the assertion macro header.
`include "gbf_to_rtf_markup_converter_unit_assert.svh"

module g2r_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] in_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       text_done
);

    // A stalled result must not change.
    `G2R_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(run_last) && $stable(text_done), "stalled result changed")

    // The end-of-text result is a lone zero byte that closes its run.
    `G2R_ASSERT_NOW(a_done_shape, clk, rst_n, out_valid && text_done, run_last && out_byte == 8'h00, "bad end-of-text result")

    // Every accepted byte is handled in a step of its own before the next one.
    `G2R_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "input taken on back-to-back cycles")

    // A zero input byte always leads to an end-of-text result, through the end step and then the output register,
    // so right after it is taken no other byte may be accepted either.
    `G2R_ASSERT_NEXT(a_end_blocks, clk, rst_n, in_valid && in_ready && in_byte == 8'h00, !in_ready, "input taken during end of text")

endmodule

bind gbf_to_rtf_markup_converter_unit g2r_checker u_g2r_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .text_done (text_done)
);
